// File: rtl/core/pftr_pkg.sv
`default_nettype none

package pftr_pkg;

    // Fixed field widths of the block's channels
    localparam int FRAME_INDEX_W   = 3;
    localparam int FAULT_W         = 16;
    localparam int FRAMES_IN_USE_W = 4;
    localparam int CFG_INDEX_W     = 4;
    localparam int CFG_DATA_W      = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_POLICY_MODE   = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAMES_IN_USE = CFG_INDEX_W'(1);

    // Reset values and limits
    localparam logic [FRAMES_IN_USE_W-1:0] FRAMES_IN_USE_RST = FRAMES_IN_USE_W'(8);
    localparam logic [FAULT_W-1:0]         FAULT_MAX         = '1;

    typedef enum logic {
        POLICY_FIFO = 1'b0,
        POLICY_LRU  = 1'b1
    } policy_t;

    typedef struct packed {
        policy_t                      policy_mode;
        logic [FRAMES_IN_USE_W-1:0]   frames_in_use;
    } cfg_t;

    typedef struct packed {
        logic                       hit;
        logic [FRAME_INDEX_W-1:0]   frame_index;
        logic [FAULT_W-1:0]         fault_count;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/pftr_item_if.sv
`default_nettype none

interface pftr_item_if #(
    parameter int PAGE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [PAGE_BITS-1:0]   page_number;
    logic                   clear_first;

    modport source (output valid, output page_number, output clear_first, input ready);
    modport sink   (input valid, input page_number, input clear_first, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pftr_result_if.sv
`default_nettype none

interface pftr_result_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   hit;
    logic [pftr_pkg::FRAME_INDEX_W-1:0]     frame_index;
    logic [pftr_pkg::FAULT_W-1:0]           fault_count;

    modport source (output valid, output hit, output frame_index, output fault_count,
                    input ready);
    modport sink   (input valid, input hit, input frame_index, input fault_count,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/pftr_cfg_if.sv
`default_nettype none

interface pftr_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [pftr_pkg::CFG_INDEX_W-1:0]   index;
    logic [pftr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/pftr_cfg_regs.sv
`default_nettype none

module pftr_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    pftr_cfg_if.sink            cfg,
    output pftr_pkg::cfg_t      cfg_q
);
    import pftr_pkg::*;

    policy_t                        policy_reg;
    logic [FRAMES_IN_USE_W-1:0]     fiu_reg;
    logic                           wr_en;

    // Writes are always taken; unknown indexes are dropped
    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_FIFO;
            fiu_reg    <= FRAMES_IN_USE_RST;
        end
        else if (wr_en)
        begin
            if (cfg.index == CFG_POLICY_MODE)
            begin
                policy_reg <= policy_t'(cfg.data[0]);
            end
            if (cfg.index == CFG_FRAMES_IN_USE)
            begin
                fiu_reg <= cfg.data[FRAMES_IN_USE_W-1:0];
            end
        end
    end

    assign cfg_q.policy_mode   = policy_reg;
    assign cfg_q.frames_in_use = fiu_reg;

endmodule

`default_nettype wire

// File: rtl/core/pftr_frame_table.sv
`default_nettype none

module pftr_frame_table #(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   upd,
    input  wire logic [PAGE_BITS-1:0]   page,
    input  wire logic                   clear_first,
    input  wire pftr_pkg::cfg_t         cfg,
    output pftr_pkg::result_t           res
);
    import pftr_pkg::*;

    localparam int FIDX_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int OUT_W  = (FIDX_W > FRAME_INDEX_W) ? FIDX_W : FRAME_INDEX_W;
    localparam logic [FIDX_W-1:0] RANK_TOP = FIDX_W'(NUM_FRAMES - 1);

    // Frame state
    logic [PAGE_BITS-1:0]   page_reg  [NUM_FRAMES];
    logic [NUM_FRAMES-1:0]  valid_reg;
    logic [FIDX_W-1:0]      rank_reg  [NUM_FRAMES];
    logic [FIDX_W-1:0]      ptr_reg;
    logic [FAULT_W-1:0]     faults_reg;

    // State as seen by this reference, after an optional clear
    logic [NUM_FRAMES-1:0]  eff_valid;
    logic [FIDX_W-1:0]      eff_rank  [NUM_FRAMES];
    logic [FIDX_W-1:0]      eff_ptr;
    logic [FAULT_W-1:0]     eff_faults;

    logic [NUM_FRAMES-1:0]  active;
    logic [NUM_FRAMES-1:0]  match;
    logic [NUM_FRAMES-1:0]  empty;
    logic [NUM_FRAMES-1:0]  oldest;
    logic                   hit;
    logic [FIDX_W-1:0]      hit_idx;
    logic [FIDX_W-1:0]      empty_idx;
    logic [FIDX_W-1:0]      oldest_idx;
    logic [FIDX_W-1:0]      victim_idx;
    logic [FIDX_W-1:0]      sel_idx;
    logic [FIDX_W-1:0]      sel_rank;
    logic [FIDX_W-1:0]      succ_idx;
    logic                   touch;
    logic [OUT_W-1:0]       sel_wide;

    logic [NUM_FRAMES-1:0]  valid_next;
    logic [FIDX_W-1:0]      rank_next [NUM_FRAMES];
    logic [FIDX_W-1:0]      ptr_next;
    logic [FAULT_W-1:0]     faults_next;

    // Apply clear, build active mask
    always_comb
    begin
        eff_valid  = clear_first ? '0 : valid_reg;
        eff_ptr    = clear_first ? '0 : ptr_reg;
        eff_faults = clear_first ? '0 : faults_reg;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            eff_rank[i] = clear_first ? FIDX_W'(i) : rank_reg[i];
            active[i]   = (i == 0) || (int'(cfg.frames_in_use) > i);
        end
    end

    // Parallel tag compare, empty detect and LRU minimum
    always_comb
    begin
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            match[i]  = active[i] && eff_valid[i] && (page_reg[i] == page);
            empty[i]  = active[i] && !eff_valid[i];
            oldest[i] = active[i];
            for (int j = 0; j < NUM_FRAMES; j++)
            begin
                if (j != i && active[j] && !(eff_rank[j] > eff_rank[i]))
                begin
                    oldest[i] = 1'b0;
                end
            end
        end
    end

    // Lowest-index picks
    always_comb
    begin
        hit_idx    = '0;
        empty_idx  = '0;
        oldest_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_idx = FIDX_W'(i);
            end
            if (empty[i])
            begin
                empty_idx = FIDX_W'(i);
            end
            if (oldest[i])
            begin
                oldest_idx = FIDX_W'(i);
            end
        end
    end

    // Victim choice: empty frames first, then policy
    always_comb
    begin
        hit = |match;
        priority if (|empty)
        begin
            victim_idx = empty_idx;
        end
        else if (cfg.policy_mode == POLICY_LRU)
        begin
            victim_idx = oldest_idx;
        end
        else if (active[eff_ptr])
        begin
            victim_idx = eff_ptr;
        end
        else
        begin
            victim_idx = '0;
        end
        sel_idx  = hit ? hit_idx : victim_idx;
        sel_rank = eff_rank[sel_idx];
        touch    = !hit || (cfg.policy_mode == POLICY_LRU);
    end

    // Round-robin successor within the active set
    always_comb
    begin
        succ_idx = '0;
        for (int i = 0; i < NUM_FRAMES - 1; i++)
        begin
            if (sel_idx == FIDX_W'(i) && active[i + 1])
            begin
                succ_idx = FIDX_W'(i + 1);
            end
        end
    end

    // Next state
    always_comb
    begin
        valid_next = eff_valid;
        if (!hit)
        begin
            valid_next[sel_idx] = 1'b1;
        end
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            if (!touch)
            begin
                rank_next[i] = eff_rank[i];
            end
            else if (sel_idx == FIDX_W'(i))
            begin
                rank_next[i] = RANK_TOP;
            end
            else if (eff_rank[i] > sel_rank)
            begin
                rank_next[i] = eff_rank[i] - FIDX_W'(1);
            end
            else
            begin
                rank_next[i] = eff_rank[i];
            end
        end
        ptr_next    = (!hit && cfg.policy_mode == POLICY_FIFO) ? succ_idx : eff_ptr;
        faults_next = (!hit && eff_faults != FAULT_MAX) ? eff_faults + FAULT_W'(1)
                                                        : eff_faults;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            ptr_reg    <= '0;
            faults_reg <= '0;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                rank_reg[i] <= FIDX_W'(i);
            end
        end
        else if (upd)
        begin
            valid_reg  <= valid_next;
            ptr_reg    <= ptr_next;
            faults_reg <= faults_next;
            for (int i = 0; i < NUM_FRAMES; i++)
            begin
                rank_reg[i] <= rank_next[i];
            end
        end
    end

    // Page tags, gated by valid bits
    always_ff @(posedge clk)
    begin
        if (upd && !hit)
        begin
            page_reg[sel_idx] <= page;
        end
    end

    assign sel_wide        = OUT_W'(sel_idx);
    assign res.hit         = hit;
    assign res.frame_index = sel_wide[FRAME_INDEX_W-1:0];
    assign res.fault_count = faults_next;

    // Rank permutation check
    logic [NUM_FRAMES-1:0] rank_seen;
    logic                  rank_perm_ok;

    always_comb
    begin
        rank_seen = '0;
        for (int i = 0; i < NUM_FRAMES; i++)
        begin
            rank_seen[rank_reg[i]] = 1'b1;
        end
        rank_perm_ok = &rank_seen;
    end

    a_rank_perm: assert property (@(posedge clk) disable iff (!rst_n)
        rank_perm_ok)
        else $error("frame ranks are not a permutation");

    a_sel_valid: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> valid_reg[$past(sel_idx)])
        else $error("referenced frame not valid after update");

    a_fault_step: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !hit && eff_faults != FAULT_MAX) |=>
            faults_reg == FAULT_W'($past(eff_faults) + FAULT_W'(1)))
        else $error("fault count did not advance on a miss");

    a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && hit) |=> faults_reg == $past(eff_faults))
        else $error("fault count changed on a hit");

    a_fifo_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (upd && !hit && cfg.policy_mode == POLICY_FIFO) |=>
            (ptr_reg == '0 || ptr_reg == FIDX_W'($past(sel_idx) + FIDX_W'(1))))
        else $error("round-robin pointer did not follow the victim");

endmodule

`default_nettype wire

// File: rtl/core/page_frame_replacement_tracker.sv
`default_nettype none

// Fully associative page frame tracker with FIFO (round robin) or LRU replacement.
// Each page reference on the item channel is compared against all valid active
// frames in parallel; a miss loads the page into the first empty active frame,
// or else into the round-robin or least recently used frame, and bumps a
// saturating fault count. One reference is accepted every cycle while the result
// channel is not stalled; each passes through the input register and then the
// result register, around the combinational tag compare and rank update. A
// stalled result holds the input register, so at most two references are in
// flight. Frame state resets at once, so no clearing pass follows reset.
// Configuration (policy, active frame count) may only be written while no
// reference is in flight.
module page_frame_replacement_tracker #(
    parameter int NUM_FRAMES = 8,
    parameter int PAGE_BITS  = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pftr_item_if.sink       item,
    pftr_result_if.source   result,
    pftr_cfg_if.sink        cfg
);
    import pftr_pkg::*;

    cfg_t                   cfg_q;
    result_t                res;

    logic                   in_valid_reg;
    logic [PAGE_BITS-1:0]   in_page_reg;
    logic                   in_clear_reg;
    logic                   out_valid_reg;
    result_t                out_res_reg;

    logic                   advance;
    logic                   in_load;

    pftr_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    pftr_frame_table #(
        .NUM_FRAMES (NUM_FRAMES),
        .PAGE_BITS  (PAGE_BITS)
    ) u_frame_table (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (advance),
        .page        (in_page_reg),
        .clear_first (in_clear_reg),
        .cfg         (cfg_q),
        .res         (res)
    );

    // Handshake: input stage moves on when the result register is free
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_load    = item.valid && item.ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            in_page_reg  <= item.page_number;
            in_clear_reg <= item.clear_first;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.hit         = out_res_reg.hit;
    assign result.frame_index = out_res_reg.frame_index;
    assign result.fault_count = out_res_reg.fault_count;

endmodule

`default_nettype wire
